// ----- hw/rtl/bmhq_pkg.sv -----
`default_nettype none

package bmhq_pkg;

   // Default heap depth
   localparam int CAPACITY_DEF = 128;

   // Field widths
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   // Result of one transaction, handed from the sequencer to the output stage
   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] removed_value;
      logic [STATUS_W-1:0]      status;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bmhq_ram.sv -----
`default_nettype none

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bmhq_ctrl.sv -----
`default_nettype none

module bmhq_ctrl
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // incoming transaction
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_op,
   input  wire logic signed [DATA_W-1:0]    req_value,
   // finished result
   output logic                             res_valid,
   input  wire logic                        res_ready,
   output result_type                       res,
   // heap memory
   output logic                             mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
   output logic signed [DATA_W-1:0]         mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
   input  wire logic signed [DATA_W-1:0]    mem_rd_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = IW + 2;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_UP    = 4'd1;
   localparam logic [3:0] S_UPFIN = 4'd2;
   localparam logic [3:0] S_ROOT  = 4'd3;
   localparam logic [3:0] S_LAST  = 4'd4;
   localparam logic [3:0] S_DNL   = 4'd5;
   localparam logic [3:0] S_DNR   = 4'd6;
   localparam logic [3:0] S_DNFIN = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]               state_ff,   state_in;
   logic [CW-1:0]            count_ff,   count_in;
   logic [IW-1:0]            hole_ff,    hole_in;
   logic [IW-1:0]            lidx_ff,    lidx_in;
   logic signed [DATA_W-1:0] val_ff,     val_in;
   logic signed [DATA_W-1:0] left_ff,    left_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;
   logic [STATUS_W-1:0]      status_ff,  status_in;

   logic [IW-1:0]            parent_idx;
   logic [LW-1:0]            right_idx;
   logic [LW-1:0]            next_left;
   logic [LW-1:0]            count_ext;
   logic                     do_move;
   logic [IW-1:0]            move_idx;
   logic signed [DATA_W-1:0] move_val;

   // Index arithmetic around the hole
   assign parent_idx = (hole_ff - IW'(1)) >> 1;
   assign right_idx  = LW'(lidx_ff) + LW'(1);
   assign next_left  = {1'b0, move_idx, 1'b1};
   assign count_ext  = LW'(count_ff);

   assign res.status        = status_ff;
   assign res.removed_value = removed_ff;
   assign res.count         = COUNT_W'(count_ff);

   // Sift sequencer: the moving value stays in val_ff, the memory sees only the hole moves
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      hole_in     = hole_ff;
      lidx_in     = lidx_ff;
      val_in      = val_ff;
      left_in     = left_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = hole_ff;
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      do_move     = 1'b0;
      move_idx    = lidx_ff;
      move_val    = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in  = STAT_OK;
               removed_in = '0;
               if (req_op == OP_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = STAT_FULL;
                     state_in  = S_RESP;
                  end else begin
                     val_in   = req_value;
                     hole_in  = IW'(count_ff);
                     count_in = count_ff + CW'(1);
                     if (count_ff == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = req_value;
                        state_in    = S_RESP;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IW'((count_ff - CW'(1)) >> 1);
                        state_in    = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     count_in    = count_ff - CW'(1);
                     state_in    = S_ROOT;
                  end
               end
            end
         end

         // parent value in mem_rd_data
         S_UP: begin
            mem_wr_en = 1'b1;
            if (mem_rd_data < val_ff) begin
               mem_wr_data = mem_rd_data;
               hole_in     = parent_idx;
               if (parent_idx == '0) begin
                  state_in = S_UPFIN;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = (parent_idx - IW'(1)) >> 1;
               end
            end else begin
               state_in = S_RESP;
            end
         end

         S_UPFIN: begin
            mem_wr_en = 1'b1;
            state_in  = S_RESP;
         end

         // root value in mem_rd_data
         S_ROOT: begin
            removed_in = mem_rd_data;
            if (count_ff == '0) begin
               state_in = S_RESP;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = IW'(count_ff);
               state_in    = S_LAST;
            end
         end

         // last entry in mem_rd_data, it becomes the moving value
         S_LAST: begin
            val_in  = mem_rd_data;
            hole_in = '0;
            if (count_ff >= CW'(2)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = IW'(1);
               lidx_in     = IW'(1);
               state_in    = S_DNL;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               mem_wr_data = mem_rd_data;
               state_in    = S_RESP;
            end
         end

         // left child value in mem_rd_data
         S_DNL: begin
            left_in = mem_rd_data;
            if (right_idx < count_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = IW'(right_idx);
               state_in    = S_DNR;
            end else if (val_ff < mem_rd_data) begin
               do_move  = 1'b1;
               move_idx = lidx_ff;
               move_val = mem_rd_data;
            end else begin
               mem_wr_en = 1'b1;
               state_in  = S_RESP;
            end
         end

         // right child value in mem_rd_data, left one in left_ff
         S_DNR: begin
            if (left_ff < mem_rd_data) begin
               move_idx = IW'(right_idx);
               move_val = mem_rd_data;
            end else begin
               move_idx = lidx_ff;
               move_val = left_ff;
            end
            if (val_ff < move_val) begin
               do_move = 1'b1;
            end else begin
               mem_wr_en = 1'b1;
               state_in  = S_RESP;
            end
         end

         S_DNFIN: begin
            mem_wr_en = 1'b1;
            state_in  = S_RESP;
         end

         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Child moves up into the hole; fetch the next left child if there is one
      if (do_move) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = move_val;
         hole_in     = move_idx;
         if (next_left < count_ext) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = IW'(next_left);
            lidx_in     = IW'(next_left);
            state_in    = S_DNL;
         end else begin
            state_in = S_DNFIN;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      hole_ff    <= hole_in;
      lidx_ff    <= lidx_in;
      val_ff     <= val_in;
      left_ff    <= left_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/binary_max_heap_queue_core.sv -----
// Insert: the new value climbs one level at a time, with one parent read per level.
// Remove: reads the root; the last entry then sinks level by level, one memory read per child.
// At 128 entries a remove sinks at most six levels. The next transaction is accepted in the
// cycle after its result is registered, one at a time, bounded by the single read port of
// the heap memory. A held output stalls the sequencer.
// Reset clears the entry count and control; heap memory is not cleared and is never
// read above the count.
`default_nettype none

module binary_max_heap_queue_core
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tuser,   // [0] operation
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] removed_value, [39:32] count
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   localparam int IW = $clog2(CAPACITY);

   logic                     mem_wr_en;
   logic [IW-1:0]            mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [IW-1:0]            mem_rd_addr;
   logic signed [DATA_W-1:0] mem_rd_data;

   logic                     res_valid;
   logic                     res_ready;
   result_type               res;

   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_data_ff,  rsp_data_in;

   // Heap storage
   bmhq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sift sequencer
   bmhq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_value   (req_tdata),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.count, rsp_data_ff.removed_value};
   assign rsp_tuser  = rsp_data_ff.status;

endmodule

`default_nettype wire
